// ----- design/hrcm_pkg.sv -----
// ----------------------------------------------------------------------------
// hrcm_pkg
// Shared types and constants of the height rainbow color map.
// ----------------------------------------------------------------------------
package hrcm_pkg;

  localparam int DEF_HEIGHT_BITS = 16;
  localparam int COLOR_W         = 8;
  localparam int CFG_IDX_W       = 2;

  typedef logic [COLOR_W-1:0]   color_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_HEIGHT_MIN = 2'd0;
  localparam cfg_idx_t REG_HEIGHT_MAX = 2'd1;

  localparam int SEG_COUNT = 6;

  localparam int SLOPE_NUM_ORANGE = 153;
  localparam int SLOPE_NUM_YELLOW = 102;
  localparam int SLOPE_NUM_FULL   = 255;
  localparam int SLOPE_NUM_HALF   = 51;

  localparam color_t COLOR_FULL     = 8'd255;
  localparam color_t COLOR_NONE     = 8'd0;
  localparam color_t ORANGE_GREEN   = 8'd153;
  localparam color_t PURPLE_RED     = 8'd102;
  localparam color_t PURPLE_BLUE    = 8'd204;

endpackage

// ----- design/hrcm_in_if.sv -----
// ----------------------------------------------------------------------------
// hrcm_in_if
// Height sample channel: valid/ready with one signed height per word.
// ----------------------------------------------------------------------------
interface hrcm_in_if #(
  parameter int HEIGHT_BITS = hrcm_pkg::DEF_HEIGHT_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

// ----- design/hrcm_out_if.sv -----
// ----------------------------------------------------------------------------
// hrcm_out_if
// Color channel: valid/ready with one RGB triple per word.
// ----------------------------------------------------------------------------
interface hrcm_out_if;
  import hrcm_pkg::*;

  logic   valid;
  logic   ready;
  color_t red;
  color_t green;
  color_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- design/hrcm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// hrcm_cfg_if
// Register write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface hrcm_cfg_if #(
  parameter int HEIGHT_BITS = hrcm_pkg::DEF_HEIGHT_BITS
);
  import hrcm_pkg::*;

  logic                   valid;
  logic                   ready;
  cfg_idx_t               index;
  logic [HEIGHT_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/height_rainbow_color_map.sv -----
// ----------------------------------------------------------------------------
// height_rainbow_color_map
// Maps a signed height sample to a rainbow RGB color between two programmed
// limits.
// ----------------------------------------------------------------------------
// Takes one height word per clock, unless busy deriving the scale, and
// returns one color word per height through a five-stage pipeline (clamp,
// offset, segment, ramp multiply, color). Output backpressure stalls only
// the stages that are full. After reset and after every register write the
// block derives the segment width by a reciprocal multiplication and the
// four ramp slopes with one shared restoring divider (one quotient bit per
// cycle); in_ch.ready stays low until the slopes are done, or only for the
// range check when the range is below 6 or inverted.
// Registers: 0 height_min, 1 height_max; other indexes are ignored.
// ----------------------------------------------------------------------------
module height_rainbow_color_map #(
  parameter int HEIGHT_BITS = hrcm_pkg::DEF_HEIGHT_BITS
) (
  input logic        clk,
  input logic        rst_n,
  hrcm_in_if.sink    in_ch,
  hrcm_out_if.source out_ch,
  hrcm_cfg_if.sink   cfg_ch
);
  import hrcm_pkg::*;

  localparam int HB    = HEIGHT_BITS;
  localparam int W     = HEIGHT_BITS + 1;
  localparam int DW    = (W > COLOR_W) ? W : COLOR_W;
  localparam int CNT_W = $clog2(DW);
  localparam int PW    = W + COLOR_W;

  // range / 6 = ((range >> 1) * ceil(2^HB / 3)) >> HB
  localparam longint unsigned RECIP_L = ((64'd1 << HB) + 64'd2) / 64'd3;
  localparam logic [HB-2:0]   RECIP   = (HB-1)'(RECIP_L);

  typedef enum logic [1:0] {ST_IDLE, ST_RANGE, ST_LOAD, ST_DIV} seq_state_t;
  typedef enum logic [2:0] {OP_STEP, OP_BOUND, OP_S153, OP_S102, OP_S255, OP_S51} div_op_t;
  typedef enum logic [2:0] {
    SEG_ORANGE, SEG_YELLOW, SEG_GREEN, SEG_BLUE, SEG_PURPLE, SEG_TOP
  } seg_t;

  // configuration and derived scale
  seq_state_t            state_r;
  div_op_t               op_r;
  logic signed [HB-1:0]  hmin_r, hmax_r;
  logic [W-1:0]          range_r;
  logic                  inv_r, small_r;
  logic [W-1:0]          step_r;
  logic [W-1:0]          bnd_r [1:5];
  color_t                s153_r, s102_r, s255_r, s51_r;
  logic [DW-1:0]         dvd_r, dvs_r, rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy;

  logic signed [W-1:0]   hmin_ext, hmax_ext, range_full;
  logic [2*HB-3:0]       step_prod;
  logic [DW:0]           rem_sh;
  logic                  q_bit;
  logic [DW-1:0]         rem_new, dvd_new;

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign hmin_ext   = {hmin_r[HB-1], hmin_r};
  assign hmax_ext   = {hmax_r[HB-1], hmax_r};
  assign range_full = hmax_ext - hmin_ext;

  assign step_prod = (2*HB-2)'(range_r[HB-1:1]) * (2*HB-2)'(RECIP);

  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign q_bit   = (rem_sh >= {1'b0, dvs_r});
  assign rem_new = q_bit ? DW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DW-1:0];
  assign dvd_new = {dvd_r[DW-2:0], q_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RANGE;
      op_r    <= OP_STEP;
      hmin_r  <= '0;
      hmax_r  <= '0;
      inv_r   <= 1'b0;
      small_r <= 1'b1;
      range_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_HEIGHT_MIN: hmin_r <= cfg_ch.data;
        REG_HEIGHT_MAX: hmax_r <= cfg_ch.data;
        default: ;
      endcase
      state_r <= ST_RANGE;
    end else begin
      case (state_r)
        ST_IDLE: ;
        ST_RANGE: begin
          inv_r   <= (hmax_r < hmin_r);
          range_r <= (hmax_r < hmin_r) ? '0 : range_full;
          small_r <= (hmax_r < hmin_r) || (range_full < W'(SEG_COUNT));
          op_r    <= OP_STEP;
          state_r <= ((hmax_r < hmin_r) || (range_full < W'(SEG_COUNT))) ? ST_IDLE : ST_LOAD;
        end
        ST_LOAD: begin
          rem_r <= '0;
          cnt_r <= '0;
          case (op_r)
            OP_STEP: begin
              step_r <= W'(step_prod >> HB);
              op_r   <= OP_BOUND;
            end
            OP_BOUND: begin
              bnd_r[1] <= step_r;
              bnd_r[2] <= step_r << 1;
              bnd_r[3] <= step_r + (step_r << 1);
              bnd_r[4] <= step_r << 2;
              bnd_r[5] <= step_r + (step_r << 2);
              op_r     <= OP_S153;
            end
            OP_S153: begin
              dvd_r   <= DW'(SLOPE_NUM_ORANGE);
              dvs_r   <= DW'(step_r);
              state_r <= ST_DIV;
            end
            OP_S102: begin
              dvd_r   <= DW'(SLOPE_NUM_YELLOW);
              dvs_r   <= DW'(step_r);
              state_r <= ST_DIV;
            end
            OP_S255: begin
              dvd_r   <= DW'(SLOPE_NUM_FULL);
              dvs_r   <= DW'(step_r);
              state_r <= ST_DIV;
            end
            default: begin
              dvd_r   <= DW'(SLOPE_NUM_HALF);
              dvs_r   <= DW'(step_r);
              state_r <= ST_DIV;
            end
          endcase
        end
        ST_DIV: begin
          rem_r <= rem_new;
          dvd_r <= dvd_new;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DW - 1)) begin
            case (op_r)
              OP_S153: begin
                s153_r  <= dvd_new[COLOR_W-1:0];
                op_r    <= OP_S102;
                state_r <= ST_LOAD;
              end
              OP_S102: begin
                s102_r  <= dvd_new[COLOR_W-1:0];
                op_r    <= OP_S255;
                state_r <= ST_LOAD;
              end
              OP_S255: begin
                s255_r  <= dvd_new[COLOR_W-1:0];
                op_r    <= OP_S51;
                state_r <= ST_LOAD;
              end
              default: begin
                s51_r   <= dvd_new[COLOR_W-1:0];
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // pipeline
  logic                 v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                 rdy1, rdy2, rdy3, rdy4, rdy5;
  logic                 in_v;

  logic signed [HB-1:0] hc1_r;
  logic [W-1:0]         i2_r;
  seg_t                 seg3_r, seg4_r;
  logic [W-1:0]         d3_r;
  logic                 zero3_r, top3_r, zero4_r, top4_r;
  color_t               pa4_r, pb4_r;
  color_t               red_r, green_r, blue_r;

  logic signed [HB-1:0] h_clamp;
  logic signed [W-1:0]  hc1_ext;
  logic [W-1:0]         i_off;
  logic [W:0]           dk [1:5];
  seg_t                 seg_nxt;
  logic [W-1:0]         d_nxt;
  color_t               slope_a;
  logic [PW-1:0]        pa_full, pb_full;
  color_t               red_nxt, green_nxt, blue_nxt;

  assign rdy5 = !v5_r || out_ch.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_ch.ready = rdy1 && !busy;
  assign in_v        = in_ch.valid && !busy;

  always_comb begin
    if (inv_r || (in_ch.height < hmin_r)) begin
      h_clamp = hmin_r;
    end else if (in_ch.height > hmax_r) begin
      h_clamp = hmax_r;
    end else begin
      h_clamp = in_ch.height;
    end
  end

  assign hc1_ext = {hc1_r[HB-1], hc1_r};
  assign i_off   = hc1_ext - hmin_ext;

  always_comb begin
    for (int k = 1; k <= 5; k++) begin
      dk[k] = {1'b0, i2_r} - {1'b0, bnd_r[k]};
    end
    if (!dk[5][W]) begin
      seg_nxt = SEG_TOP;
      d_nxt   = dk[5][W-1:0];
    end else if (!dk[4][W]) begin
      seg_nxt = SEG_PURPLE;
      d_nxt   = dk[4][W-1:0];
    end else if (!dk[3][W]) begin
      seg_nxt = SEG_BLUE;
      d_nxt   = dk[3][W-1:0];
    end else if (!dk[2][W]) begin
      seg_nxt = SEG_GREEN;
      d_nxt   = dk[2][W-1:0];
    end else if (!dk[1][W]) begin
      seg_nxt = SEG_YELLOW;
      d_nxt   = dk[1][W-1:0];
    end else begin
      seg_nxt = SEG_ORANGE;
      d_nxt   = i2_r;
    end
  end

  always_comb begin
    case (seg3_r)
      SEG_ORANGE: slope_a = s153_r;
      SEG_YELLOW: slope_a = s102_r;
      SEG_GREEN:  slope_a = s255_r;
      SEG_BLUE:   slope_a = s255_r;
      SEG_PURPLE: slope_a = s102_r;
      default:    slope_a = '0;
    endcase
  end

  assign pa_full = PW'(d3_r) * PW'(slope_a);
  assign pb_full = PW'(d3_r) * PW'(s51_r);

  always_comb begin
    if (small_r) begin
      if (zero4_r) begin
        red_nxt = COLOR_FULL;  green_nxt = COLOR_NONE; blue_nxt = COLOR_NONE;
      end else if (top4_r) begin
        red_nxt = PURPLE_RED;  green_nxt = COLOR_NONE; blue_nxt = PURPLE_BLUE;
      end else begin
        red_nxt = COLOR_NONE;  green_nxt = COLOR_FULL; blue_nxt = COLOR_NONE;
      end
    end else begin
      case (seg4_r)
        SEG_ORANGE: begin
          red_nxt = COLOR_FULL; green_nxt = pa4_r; blue_nxt = COLOR_NONE;
        end
        SEG_YELLOW: begin
          red_nxt = COLOR_FULL; green_nxt = ORANGE_GREEN + pa4_r; blue_nxt = COLOR_NONE;
        end
        SEG_GREEN: begin
          red_nxt = COLOR_FULL - pa4_r; green_nxt = COLOR_FULL; blue_nxt = COLOR_NONE;
        end
        SEG_BLUE: begin
          red_nxt = COLOR_NONE; green_nxt = COLOR_FULL - pa4_r; blue_nxt = pa4_r;
        end
        SEG_PURPLE: begin
          red_nxt = pa4_r; green_nxt = COLOR_NONE; blue_nxt = COLOR_FULL - pb4_r;
        end
        default: begin
          red_nxt = PURPLE_RED; green_nxt = COLOR_NONE; blue_nxt = PURPLE_BLUE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_v;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      hc1_r <= h_clamp;
    end
    if (rdy2) begin
      i2_r <= i_off;
    end
    if (rdy3) begin
      seg3_r  <= seg_nxt;
      d3_r    <= d_nxt;
      zero3_r <= (i2_r == '0);
      top3_r  <= (i2_r == range_r);
    end
    if (rdy4) begin
      seg4_r  <= seg3_r;
      zero4_r <= zero3_r;
      top4_r  <= top3_r;
      pa4_r   <= pa_full[COLOR_W-1:0];
      pb4_r   <= pb_full[COLOR_W-1:0];
    end
    if (rdy5) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid = v5_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

endmodule

// ----- tb/sv/height_rainbow_color_map_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// height_rainbow_color_map_tb
// Self-checking bench for the height rainbow color map. Heights are driven
// under a series of min/max settings. Each color word is predicted as the
// height is accepted and is compared field by field with the block output.
// Both sides idle at random, and the output is held off once for a long time.
// ----------------------------------------------------------------------------
module height_rainbow_color_map_tb;
  import hrcm_pkg::*;

  localparam int HB = DEF_HEIGHT_BITS;
  localparam longint H_LO = -(longint'(1) << (HB - 1));
  localparam longint H_HI = (longint'(1) << (HB - 1)) - 1;
  localparam cfg_idx_t REG_SPARE_2 = 2'd2;
  localparam cfg_idx_t REG_SPARE_3 = 2'd3;
  localparam int MAX_WAIT      = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_ITEMS   = 108;

  typedef logic signed [HB-1:0] height_t;
  typedef struct packed {
    color_t red;
    color_t green;
    color_t blue;
  } rgb_t;
  typedef struct {
    height_t height;
    rgb_t    color;
  } color_expect_t;
  typedef enum int {
    SCALE_WIDE, SCALE_TINY, SCALE_INVERTED, SCALE_NARROW, SCALE_MEDIUM, SCALE_FULL
  } scale_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hrcm_in_if  #(.HEIGHT_BITS(HB)) in_ch();
  hrcm_out_if                     out_ch();
  hrcm_cfg_if #(.HEIGHT_BITS(HB)) cfg_ch();

  height_rainbow_color_map #(.HEIGHT_BITS(HB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  height_t       scale_min = '0;
  height_t       scale_max = '0;
  height_t       height_queue[$];
  color_expect_t color_queue[$];

  int   tx_gap = 0;
  int   rx_stall = 0;
  int   tx_max_gap = 0;
  int   rx_max_stall = 0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  logic rx_hold = 1'b0;

  int items_queued = 0;
  int colors_done = 0;
  int error_count = 0;
  int settings_count = 0;
  int small_settings = 0;
  int inverted_settings = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  function automatic rgb_t rainbow_color(height_t h);
    longint lo, hi, span, ofs, step, d;
    rgb_t c;
    lo = scale_min;
    hi = scale_max;
    if (hi < lo) begin
      span = 0;
      ofs = 0;
    end else begin
      span = hi - lo;
      if (longint'(h) < lo) ofs = 0;
      else if (longint'(h) > hi) ofs = span;
      else ofs = longint'(h) - lo;
    end
    if (span < SEG_COUNT) begin
      if (ofs == 0) c = '{COLOR_FULL, COLOR_NONE, COLOR_NONE};
      else if (ofs == span) c = '{PURPLE_RED, COLOR_NONE, PURPLE_BLUE};
      else c = '{COLOR_NONE, COLOR_FULL, COLOR_NONE};
      return c;
    end
    step = span / SEG_COUNT;
    if (ofs < step) begin
      c = '{COLOR_FULL, color_t'(ofs * (SLOPE_NUM_ORANGE / step)), COLOR_NONE};
    end else if (ofs < 2 * step) begin
      d = ofs - step;
      c = '{COLOR_FULL, color_t'(SLOPE_NUM_ORANGE + d * (SLOPE_NUM_YELLOW / step)),
            COLOR_NONE};
    end else if (ofs < 3 * step) begin
      d = ofs - 2 * step;
      c = '{color_t'(SLOPE_NUM_FULL - d * (SLOPE_NUM_FULL / step)), COLOR_FULL,
            COLOR_NONE};
    end else if (ofs < 4 * step) begin
      d = ofs - 3 * step;
      c = '{COLOR_NONE, color_t'(SLOPE_NUM_FULL - d * (SLOPE_NUM_FULL / step)),
            color_t'(d * (SLOPE_NUM_FULL / step))};
    end else if (ofs < 5 * step) begin
      d = ofs - 4 * step;
      c = '{color_t'(d * (SLOPE_NUM_YELLOW / step)), COLOR_NONE,
            color_t'(SLOPE_NUM_FULL - d * (SLOPE_NUM_HALF / step))};
    end else begin
      c = '{PURPLE_RED, COLOR_NONE, PURPLE_BLUE};
    end
    return c;
  endfunction

  function automatic int draw_wait(int top);
    if ($urandom_range(0, 1) != 0) return 0;
    return int'($urandom_range(0, top));
  endfunction

  task automatic report_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // height driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.height <= '0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        color_queue.push_back('{in_ch.height, rainbow_color(in_ch.height)});
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (height_queue.size() > 0) begin
          in_ch.valid  <= 1'b1;
          in_ch.height <= height_queue.pop_front();
          tx_gap = draw_wait(tx_max_gap);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // color sink ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_stall = draw_wait(rx_max_stall);
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !rx_hold;
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) rx_hold <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      rx_hold <= 1'b1;
    end
  end

  // color monitor
  always @(posedge clk) begin : color_monitor
    color_expect_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (color_queue.size() == 0) begin
        report_error($sformatf("color word r=%0d g=%0d b=%0d with nothing expected",
                               out_ch.red, out_ch.green, out_ch.blue));
      end else begin
        want = color_queue.pop_front();
        colors_done++;
        if (out_ch.red !== want.color.red)
          report_error($sformatf("height %0d: red %0d, expected %0d",
                                 want.height, out_ch.red, want.color.red));
        if (out_ch.green !== want.color.green)
          report_error($sformatf("height %0d: green %0d, expected %0d",
                                 want.height, out_ch.green, want.color.green));
        if (out_ch.blue !== want.color.blue)
          report_error($sformatf("height %0d: blue %0d, expected %0d",
                                 want.height, out_ch.blue, want.color.blue));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d colors seen",
               cycle_count, colors_done, items_queued);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // caller sits on a rising edge; returns at the edge after the handshake
  task automatic write_reg(cfg_idx_t idx, height_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_HEIGHT_MIN) scale_min = value;
    else if (idx == REG_HEIGHT_MAX) scale_max = value;
    @(posedge clk);
  endtask

  task automatic set_scale(longint lo, longint hi);
    write_reg(REG_HEIGHT_MIN, height_t'(lo));
    write_reg(REG_HEIGHT_MAX, height_t'(hi));
    settings_count++;
    if (hi < lo) inverted_settings++;
    else if (hi - lo < SEG_COUNT) small_settings++;
  endtask

  task automatic push_height(longint h);
    height_queue.push_back(height_t'(h));
    items_queued++;
  endtask

  task automatic wait_idle();
    while (colors_done != items_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic pick_scale(scale_kind_t kind, output longint lo, output longint hi);
    longint a, b, span;
    case (kind)
      SCALE_WIDE: begin
        a = longint'(height_t'($urandom));
        b = longint'(height_t'($urandom));
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      SCALE_TINY: begin
        lo = H_LO + $urandom_range(0, 65530);
        hi = lo + $urandom_range(0, 5);
      end
      SCALE_INVERTED: begin
        lo = H_LO + 1 + $urandom_range(0, 65534);
        hi = lo - 1 - $urandom_range(0, lo - H_LO - 1);
      end
      SCALE_NARROW, SCALE_MEDIUM: begin
        span = (kind == SCALE_NARROW) ? $urandom_range(6, 40) : $urandom_range(41, 3000);
        lo = H_LO + $urandom_range(0, 65535 - span);
        hi = lo + span;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: begin lo = H_HI; hi = H_HI; end
          1: begin lo = H_LO; hi = H_LO; end
          2: begin lo = H_HI; hi = H_LO; end
          3: begin lo = H_LO; hi = H_LO + 5; end
          default: begin lo = H_LO; hi = H_HI; end
        endcase
      end
    endcase
  endtask

  task automatic push_random_heights(longint lo, longint hi, int n);
    longint pick, span;
    span = hi - lo;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: pick = longint'(height_t'($urandom));
        1: pick = (($urandom_range(0, 1) != 0) ? lo : hi) + int'($urandom_range(0, 2)) - 1;
        2: begin
          if (span >= SEG_COUNT)
            pick = lo + (span / SEG_COUNT) * int'($urandom_range(0, SEG_COUNT))
                   + int'($urandom_range(0, 2)) - 1;
          else
            pick = lo + int'($urandom_range(0, 2)) - 1;
        end
        default: begin
          if (span >= 0) pick = lo + $urandom_range(0, span);
          else pick = longint'(height_t'($urandom));
        end
      endcase
      if (pick < H_LO) pick = H_LO;
      if (pick > H_HI) pick = H_HI;
      push_height(pick);
    end
  endtask

  initial begin
    longint lo, hi;
    scale_kind_t kind;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_HEIGHT_MIN;
    cfg_ch.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset scale is min = max = 0: everything red
    push_height(H_LO);
    push_height(H_HI);
    wait_idle();

    // six segments of width 10, their edges, and clamping on both sides
    set_scale(-10, 50);
    push_height(-10);
    push_height(0);
    push_height(9);
    push_height(10);
    push_height(20);
    push_height(30);
    push_height(40);
    push_height(49);
    push_height(50);
    push_height(H_LO);
    push_height(H_HI);
    wait_idle();

    // three-color scale, then writes to unused indexes must change nothing
    set_scale(100, 103);
    push_height(99);
    push_height(100);
    push_height(101);
    push_height(103);
    push_height(104);
    wait_idle();
    write_reg(REG_SPARE_2, height_t'($urandom));
    write_reg(REG_SPARE_3, height_t'($urandom));
    push_height(103);
    wait_idle();

    // max below min: red whatever the height
    set_scale(5, -5);
    push_height(H_LO);
    push_height(H_HI);
    wait_idle();

    set_scale(H_LO, H_HI);
    push_height(H_LO);
    push_height(0);
    push_height(H_HI);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = scale_kind_t'(p % 6);
      pick_scale(kind, lo, hi);
      set_scale(lo, hi);
      if (p == 0) begin
        tx_max_gap = 0;
        rx_max_stall = 0;
      end else if (p == 1) begin
        tx_max_gap = 0;
        rx_max_stall = MAX_WAIT;
        hold_requests <= hold_requests + 1;
      end else begin
        tx_max_gap = ($urandom_range(0, 3) != 0) ? MAX_WAIT : 0;
        rx_max_stall = ($urandom_range(0, 3) != 0) ? MAX_WAIT : 0;
      end
      if (p == 2) begin
        push_random_heights(lo, hi, PHASE_ITEMS / 2);
        wait_idle();
        push_random_heights(lo, hi, PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        push_random_heights(lo, hi, PHASE_ITEMS);
      end
      wait_idle();
    end

    if (color_queue.size() != 0)
      report_error($sformatf("%0d colors never arrived", color_queue.size()));
    $display("Mapped %0d heights over %0d scale settings (%0d three-color, %0d inverted),",
             items_queued, settings_count, small_settings, inverted_settings);
    $display("checked %0d colors with %0d mismatches in %0d cycles.",
             colors_done, error_count, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
